FILE: rtl/core/nau_pkg.sv
// Package for the activation unit: field widths, codes and the sigmoid table generator.
package nau_pkg;

  // Default configuration of the table and the fixed-point format.
  localparam int TABLE_DEPTH = 256;
  localparam int FRAC_BITS   = 12;

  // Widths of the payload fields and the configuration port.
  localparam int SampleW   = 16;
  localparam int KindW     = 3;
  localparam int SlopeW    = 12;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 12;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ACT_KIND    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEAKY_SLOPE = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [KindW-1:0]  KIND_RESET  = 3'd0;
  localparam logic [SlopeW-1:0] SLOPE_RESET = 12'd410;

  // Activation codes.
  localparam logic [KindW-1:0] KIND_SIGMOID = 3'd0;
  localparam logic [KindW-1:0] KIND_RELU    = 3'd1;
  localparam logic [KindW-1:0] KIND_LEAKY   = 3'd2;
  localparam logic [KindW-1:0] KIND_TANH    = 3'd3;
  localparam logic [KindW-1:0] KIND_NTANH   = 3'd4;
  localparam logic [KindW-1:0] KIND_LINEAR  = 3'd5;
  localparam logic [KindW-1:0] KIND_SCALED  = 3'd6;

  // Operation codes.
  localparam logic OP_VALUE = 1'b0;
  localparam logic OP_DERIV = 1'b1;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  // Shift-and-subtract division, used only while building the table.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned rem;
    longint unsigned quo;
    rem = 64'd0;
    quo = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (64'd1 << b);
      end
    end
    return quo;
  endfunction

  // exp(-f) in Q30 for f in [0, 1.0] by a 25-term series.
  function automatic longint exp_frac(input longint f);
    longint term;
    longint sum;
    term = longint'(Q30_ONE);
    sum  = longint'(Q30_ONE);
    for (int k = 1; k <= 24; k++) begin
      term = longint'(udiv(longint'(term * f) >>> 30, 64'(k)));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Table entry i: sigmoid(8*i/depth), rounded half up to frac fraction bits.
  function automatic longint unsigned sig_rom_entry(input longint unsigned i,
                                                    input longint unsigned depth,
                                                    input int frac);
    longint unsigned t;
    longint unsigned n;
    longint e;
    longint e1;
    longint unsigned s30;
    t  = udiv(i << 33, depth);
    n  = t >> 30;
    e  = exp_frac(longint'(t & (Q30_ONE - 64'd1)));
    e1 = exp_frac(longint'(Q30_ONE));
    for (longint unsigned j = 0; j < n; j++) begin
      e = (e * e1) >>> 30;
    end
    s30 = udiv(64'd1 << 60, Q30_ONE + longint'(e));
    return (s30 + (64'd1 << (29 - frac))) >> (30 - frac);
  endfunction

endpackage

FILE: rtl/core/nau_in_if.sv
// Input channel of the activation unit: operation bit and sample.
interface nau_in_if import nau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

FILE: rtl/core/nau_out_if.sv
// Output channel of the activation unit: one saturated result.
interface nau_out_if import nau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

FILE: rtl/core/neural_activation_unit_top.sv
// Top level of the activation unit: sigmoid table RAM and the result pipeline.
//
// Usage: each transfer on in_i carries a signed sample (FracBits fraction bits)
// and an operation bit (value or derivative). Each accepted item gives exactly
// one transfer on out_o with the saturated 16-bit result, in order.
// The activation and the leaky slope are set through the write port
// (cfg_we_i, cfg_index_i, cfg_data_i) while no item is in flight.
// Path: a result passes the stage 1 registers (beside the RAM read), the stage 2
// registers and the output register before it is valid on out_o.
// Throughput: one item per cycle once the table is loaded, unless out_o is held;
// the sigmoid table RAM is read and the one multiplier used once per item.
// Reset: the registers return to sigmoid and slope 0.10, and the table RAM is
// loaded from the constant table, one entry a cycle, until every entry is written;
// in_i.ready stays low until that load is done.
// Stall: when out_o is held by the receiver the whole pipeline stops, the RAM
// read data holds, and in_i.ready drops until the output register is freed.
module neural_activation_unit_top import nau_pkg::*; #(
  parameter int TableDepth = TABLE_DEPTH,
  parameter int FracBits   = FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  nau_in_if.sink              in_i,
  nau_out_if.source           out_o
);

  localparam int AW    = $clog2(TableDepth);
  localparam int RomW  = FracBits + 1;
  localparam int DW    = FracBits + 2;
  localparam int MW    = (DW > SampleW) ? DW : SampleW;
  localparam int PW    = 2 * MW;
  localparam int RW    = PW + 2;
  localparam int SlUp  = (FracBits >= 12) ? FracBits - 12 : 0;
  localparam int SlDn  = (FracBits >= 12) ? 0 : 12 - FracBits;
  localparam logic [31:0] Span = 32'd8 << FracBits;
  localparam logic signed [DW-1:0] OneS = DW'(1) << FracBits;
  localparam logic signed [RW-1:0] OneR = RW'(1) << FracBits;
  localparam logic signed [RW-1:0] SatHi = RW'(32767);
  localparam logic signed [RW-1:0] SatLo = RW'(-32768);

  // Configuration registers.
  logic [KindW-1:0]  kind_q;
  logic [SlopeW-1:0] slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_RESET;
      slope_q <= SLOPE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ACT_KIND:    kind_q  <= cfg_data_i[KindW-1:0];
        CFG_LEAKY_SLOPE: slope_q <= cfg_data_i[SlopeW-1:0];
        default: ;
      endcase
    end
  end

  // Constant sigmoid table, built at elaboration.
  logic [RomW-1:0] rom_tbl [TableDepth];

  for (genvar g = 0; g < TableDepth; g++) begin : g_rom
    localparam logic [RomW-1:0] Entry =
        RomW'(sig_rom_entry(64'(g), 64'(TableDepth), FracBits));
    assign rom_tbl[g] = Entry;
  end

  // Load sweep of the table RAM after reset.
  logic [AW-1:0] fill_idx_q;
  logic          fill_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_idx_q  <= '0;
      fill_done_q <= 1'b0;
    end else if (!fill_done_q) begin
      if (fill_idx_q == AW'(TableDepth - 1)) begin
        fill_done_q <= 1'b1;
      end else begin
        fill_idx_q <= fill_idx_q + AW'(1);
      end
    end
  end

  // Pipeline advance: everything moves unless the output is held.
  logic out_valid_q;
  logic adv;
  logic in_fire;

  assign adv      = !(out_valid_q && !out_o.ready);
  assign in_i.ready = fill_done_q && adv;
  assign in_fire  = in_i.valid && in_i.ready;

  // Stage 0: table address from the magnitude of x, or of 2x for the tanh forms.
  logic               dbl0;
  logic signed [16:0] xin0;
  logic               neg0;
  logic [16:0]        mag0;
  logic               sat0;
  logic [31:0]        idx_prod0;
  logic [AW-1:0]      idx0;

  always_comb begin
    dbl0      = (kind_q == KIND_TANH) || (kind_q == KIND_NTANH);
    xin0      = dbl0 ? {in_i.sample, 1'b0} : {in_i.sample[SampleW-1], in_i.sample};
    neg0      = xin0[16];
    mag0      = neg0 ? 17'(-xin0) : 17'(xin0);
    sat0      = {15'd0, mag0} >= Span;
    idx_prod0 = 32'(mag0) * 32'(TableDepth);
    idx0      = AW'(idx_prod0 >> (FracBits + 3));
  end

  logic [RomW-1:0] rom_rdata;

  nau_ram #(
    .Width (RomW),
    .Depth (TableDepth)
  ) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (!fill_done_q),
    .waddr_i (fill_idx_q),
    .wdata_i (rom_tbl[fill_idx_q]),
    .re_i    (adv),
    .raddr_i (idx0),
    .rdata_o (rom_rdata)
  );

  // Stage 1 registers, alongside the RAM read.
  logic                      v1_q;
  logic                      op1_q;
  logic signed [SampleW-1:0] x1_q;
  logic                      neg1_q;
  logic                      sat1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q  <= in_i.operation;
      x1_q   <= in_i.sample;
      neg1_q <= neg0;
      sat1_q <= sat0;
    end
  end

  // Stage 1 logic: sigmoid with symmetry, tanh, and the shared multiplier.
  logic signed [DW-1:0] ent1;
  logic signed [DW-1:0] sg1;
  logic signed [DW-1:0] s1;
  logic signed [DW-1:0] t1;
  logic signed [MW-1:0] ma1;
  logic signed [MW-1:0] mb1;
  logic signed [PW-1:0] p1;

  always_comb begin
    ent1 = signed'({1'b0, rom_rdata});
    sg1  = sat1_q ? OneS : ent1;
    s1   = neg1_q ? OneS - sg1 : sg1;
    t1   = DW'(s1 <<< 1) - OneS;
    unique case (kind_q)
      KIND_SIGMOID, KIND_SCALED: begin
        ma1 = MW'(s1);
        mb1 = MW'(OneS - s1);
      end
      KIND_TANH, KIND_NTANH: begin
        ma1 = MW'(t1);
        mb1 = MW'(t1);
      end
      KIND_LEAKY: begin
        ma1 = MW'(x1_q);
        mb1 = MW'(signed'({1'b0, slope_q}));
      end
      default: begin
        ma1 = '0;
        mb1 = '0;
      end
    endcase
    p1 = ma1 * mb1;
  end

  // Stage 2 registers.
  logic                      v2_q;
  logic                      op2_q;
  logic signed [SampleW-1:0] x2_q;
  logic signed [DW-1:0]      s2_q;
  logic signed [PW-1:0]      p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q <= op1_q;
      x2_q  <= x1_q;
      s2_q  <= s1;
      p2_q  <= p1;
    end
  end

  // Stage 2 logic: select the result for the activation and saturate.
  logic signed [RW-1:0] xw2;
  logic signed [RW-1:0] sw2;
  logic signed [RW-1:0] pw2;
  logic signed [RW-1:0] pf2;
  logic signed [RW-1:0] slope_fix2;
  logic                 neg2;
  logic signed [RW-1:0] r2;
  logic signed [SampleW-1:0] res2;

  always_comb begin
    xw2        = RW'(x2_q);
    sw2        = RW'(s2_q);
    pw2        = RW'(p2_q);
    pf2        = pw2 >>> FracBits;
    slope_fix2 = (RW'(signed'({1'b0, slope_q})) <<< SlUp) >>> SlDn;
    neg2       = x2_q[SampleW-1];
    unique case (kind_q)
      KIND_SIGMOID: r2 = (op2_q == OP_DERIV) ? pf2 : sw2;
      KIND_RELU: begin
        if (op2_q == OP_DERIV) begin
          r2 = neg2 ? '0 : OneR;
        end else begin
          r2 = neg2 ? '0 : xw2;
        end
      end
      KIND_LEAKY: begin
        if (op2_q == OP_DERIV) begin
          r2 = neg2 ? slope_fix2 : OneR;
        end else begin
          r2 = neg2 ? (pw2 >>> 12) : xw2;
        end
      end
      KIND_TANH: r2 = (op2_q == OP_DERIV) ? OneR - pf2 : (sw2 <<< 1) - OneR;
      KIND_NTANH: r2 = (op2_q == OP_DERIV) ? (OneR - pf2) >>> 1 : sw2;
      KIND_LINEAR: r2 = (op2_q == OP_DERIV) ? OneR : xw2;
      KIND_SCALED: begin
        r2 = (op2_q == OP_DERIV) ? (pw2 >>> (FracBits - 1)) : (sw2 <<< 1) - OneR;
      end
      default: r2 = '0;
    endcase
    if (r2 > SatHi) begin
      res2 = SampleW'(SatHi);
    end else if (r2 < SatLo) begin
      res2 = SampleW'(SatLo);
    end else begin
      res2 = SampleW'(r2);
    end
  end

  // Output register.
  logic signed [SampleW-1:0] result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_q <= res2;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.result = result_q;

endmodule

FILE: rtl/core/nau_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nau_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the activation unit: directed and random samples under every activation.
`timescale 1ns / 1ps

module testbench import nau_pkg::*;;

  // Run constants.
  localparam int          STALL_LIMIT    = 4000;
  localparam int          DRAIN_CYCLES   = 6;
  localparam int          PHASE_ITEMS    = 120;
  localparam int          NUM_PHASES     = 14;
  localparam logic [KindW-1:0] KIND_UNUSED = 3'd7;
  localparam longint unsigned  Q30_UNIT  = 64'd1 << 30;
  localparam longint      ONE_FIX        = longint'(1) << FRAC_BITS;
  localparam longint      SPAN_FIX       = longint'(8) << FRAC_BITS;

  typedef struct packed {
    logic                      operation;
    logic signed [SampleW-1:0] sample;
  } act_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  nau_in_if  in_ch ();
  nau_out_if out_ch ();

  neural_activation_unit_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Testbench state: pending samples, expected results and the register copies.
  act_item_t                 pending_items[$];
  logic signed [SampleW-1:0] results_due[$];
  longint                    sig_table[TABLE_DEPTH];
  logic [KindW-1:0]          kind_copy;
  logic [SlopeW-1:0]         slope_copy;
  int unsigned               send_idle_pct;
  int unsigned               recv_stall_pct;
  int                        idle_cycles;
  int                        mismatches;
  int                        items_sent;
  int                        results_checked;

  always #1 clk_i = ~clk_i;

  // exp(-f) in Q30 for f in [0, 1.0] by a 25-term series.
  function automatic longint exp_neg_q30(input longint f);
    longint term;
    longint total;
    term  = longint'(Q30_UNIT);
    total = longint'(Q30_UNIT);
    for (int k = 1; k <= 24; k++) begin
      term = (term * f) / longint'(Q30_UNIT) / longint'(k);
      if ((k % 2) == 1) begin
        total = total - term;
      end else begin
        total = total + term;
      end
    end
    return total;
  endfunction

  // Sigmoid of 8*i/TABLE_DEPTH, rounded half up to FRAC_BITS fraction bits.
  function automatic longint sigmoid_entry(input int unsigned i);
    longint unsigned t;
    longint unsigned n;
    longint unsigned s30;
    longint          e;
    longint          e1;
    t  = (64'(i) << 33) / 64'(TABLE_DEPTH);
    n  = t >> 30;
    e  = exp_neg_q30(longint'(t & (Q30_UNIT - 64'd1)));
    e1 = exp_neg_q30(longint'(Q30_UNIT));
    for (longint unsigned j = 0; j < n; j++) begin
      e = (e * e1) >>> 30;
    end
    s30 = (64'd1 << 60) / (Q30_UNIT + 64'(e));
    return longint'((s30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
  endfunction

  // Table sigmoid with symmetry for negative inputs and saturation at 8.0.
  function automatic longint sampled_sigmoid(input longint x);
    longint mag;
    longint s;
    mag = (x < 0) ? -x : x;
    if (mag >= SPAN_FIX) begin
      s = ONE_FIX;
    end else begin
      s = sig_table[(mag * TABLE_DEPTH) / SPAN_FIX];
    end
    return (x < 0) ? ONE_FIX - s : s;
  endfunction

  // Expected result of one sample under the current activation and slope.
  function automatic logic signed [SampleW-1:0] expected_activation(
      input logic op, input logic signed [SampleW-1:0] sample,
      input logic [KindW-1:0] kind, input logic [SlopeW-1:0] slope);
    longint x;
    longint s;
    longint t;
    longint r;
    longint slope_l;
    logic   deriv;
    x       = longint'(sample);
    slope_l = longint'({52'd0, slope});
    deriv   = (op == OP_DERIV);
    r       = 0;
    case (kind)
      KIND_SIGMOID: begin
        s = sampled_sigmoid(x);
        r = deriv ? (s * (ONE_FIX - s)) >>> FRAC_BITS : s;
      end
      KIND_RELU: begin
        if (x < 0) begin
          r = 0;
        end else begin
          r = deriv ? ONE_FIX : x;
        end
      end
      KIND_LEAKY: begin
        if (deriv) begin
          r = (x < 0) ? (slope_l << (FRAC_BITS - 12)) : ONE_FIX;
        end else begin
          r = (x < 0) ? (x * slope_l) >>> 12 : x;
        end
      end
      KIND_TANH, KIND_NTANH: begin
        s = sampled_sigmoid(2 * x);
        t = 2 * s - ONE_FIX;
        if (kind == KIND_TANH) begin
          r = deriv ? ONE_FIX - ((t * t) >>> FRAC_BITS) : t;
        end else begin
          r = deriv ? (ONE_FIX - ((t * t) >>> FRAC_BITS)) >>> 1 : s;
        end
      end
      KIND_LINEAR: begin
        r = deriv ? ONE_FIX : x;
      end
      KIND_SCALED: begin
        s = sampled_sigmoid(x);
        r = deriv ? (2 * s * (ONE_FIX - s)) >>> FRAC_BITS : 2 * s - ONE_FIX;
      end
      default: begin
        r = 0;
      end
    endcase
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[SampleW-1:0];
  endfunction

  // Random sample, biased toward the sigmoid slope, the tanh edge and the extremes.
  function automatic logic signed [SampleW-1:0] pick_sample();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom_range(65535)) - 32768;
      1: v = int'($urandom_range(16383)) - 8192;
      2: v = ($urandom_range(1) ? 16384 : -16384) + int'($urandom_range(255)) - 128;
      default: v = $urandom_range(1) ? 32767 - int'($urandom_range(255))
                                     : -32768 + int'($urandom_range(255));
    endcase
    return v[SampleW-1:0];
  endfunction

  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    if (index == CFG_ACT_KIND) begin
      kind_copy = data[KindW-1:0];
    end else begin
      slope_copy = data[SlopeW-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every queued sample has been sent and every result has come back.
  // The check runs on the falling edge, after the driver and monitor have settled.
  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_item(input logic op, input logic signed [SampleW-1:0] sample);
    act_item_t item;
    item.operation = op;
    item.sample    = sample;
    pending_items.push_back(item);
  endtask

  // Stimulus: reset, directed samples, then random phases over the activations.
  initial begin
    logic [KindW-1:0]          phase_kind[NUM_PHASES];
    logic signed [SampleW-1:0] directed[9];
    logic [SlopeW-1:0]         slope;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = CFG_ACT_KIND;
    cfg_data_i       = '0;
    kind_copy        = KIND_RESET;
    slope_copy       = SLOPE_RESET;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    idle_cycles      = 0;
    mismatches       = 0;
    items_sent       = 0;
    results_checked  = 0;
    phase_kind = '{KIND_SIGMOID, KIND_RELU, KIND_LEAKY, KIND_TANH, KIND_NTANH,
                   KIND_LINEAR, KIND_SCALED, KIND_LEAKY, KIND_TANH, KIND_SIGMOID,
                   KIND_LEAKY, KIND_SCALED, KIND_NTANH, KIND_UNUSED};
    directed = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd127,
                 16'sd128, 16'sd16384, -16'sd16385};
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sig_table[i] = sigmoid_entry(i);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset values: sigmoid, then leaky with the default slope.
    foreach (directed[i]) begin
      queue_item(OP_VALUE, directed[i]);
      queue_item(OP_DERIV, directed[i]);
    end
    wait_drained();
    write_register(CFG_ACT_KIND, CfgDataW'(KIND_LEAKY));
    queue_item(OP_VALUE, -16'sd32768);
    queue_item(OP_DERIV, -16'sd32768);
    queue_item(OP_VALUE, -16'sd4096);
    queue_item(OP_DERIV, 16'sd4096);
    wait_drained();

    // Random phases; each picks an activation, a slope and an idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (p == 2) begin
        slope = '0;
      end else if (p == 7) begin
        slope = '1;
      end else begin
        slope = SlopeW'($urandom_range(4095));
      end
      write_register(CFG_ACT_KIND, CfgDataW'(phase_kind[p]));
      write_register(CFG_LEAKY_SLOPE, CfgDataW'(slope));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_item(logic'($urandom_range(1)), pick_sample());
      end
      wait_drained();
    end

    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      mismatches++;
    end
    $display("Sent %0d samples over %0d phases covering every activation code, value and derivative.",
             items_sent, NUM_PHASES + 2);
    $display("Checked %0d results; %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Driver: presents the next pending sample, with random idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin
    act_item_t item;
    if (!rst_ni) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= OP_VALUE;
      in_ch.sample    <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_items.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.operation <= item.operation;
        in_ch.sample    <= item.sample;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure on the result channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each input transfer, checks each result transfer, and
  // ends the run when no transfer has happened for too long.
  always @(posedge clk_i) begin
    logic signed [SampleW-1:0] want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        results_due.push_back(expected_activation(in_ch.operation, in_ch.sample,
                                                  kind_copy, slope_copy));
        items_sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result transfer: result %0d", out_ch.result);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (out_ch.result !== want) begin
            $error("result mismatch: expected %0d, got %0d", want, out_ch.result);
            mismatches++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles.", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
